### sv/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for TCP congestion window and RTO
// Event and result payload types, action codes, register indexes, reset values
// and the status bundle of the serial arithmetic units.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Action codes
    localparam logic [1:0] ACT_NEW_ACK = 2'd0;
    localparam logic [1:0] ACT_DUP_ACK = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RTO_FLOOR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RTO_CEILING   = 2'd3;

    // Reset values
    localparam logic [15:0] RST_SEGMENT_SIZE  = 16'd536;
    localparam logic [3:0]  RST_DUP_THRESHOLD = 4'd3;
    localparam logic [15:0] RST_RTO_FLOOR     = 16'd200;
    localparam logic [19:0] RST_RTO_CEILING   = 20'd60000;
    localparam logic [31:0] RST_CWND          = 32'd536;
    localparam logic [31:0] RST_SSTHRESH      = 32'd65535;
    localparam logic [19:0] RST_RTO           = 20'd1000;

    localparam logic [3:0]  DUP_MAX = 4'd15;
    localparam logic [19:0] MAX20   = 20'hFFFFF;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] peer_window;
        logic        rtt_valid;
        logic [15:0] rtt_ticks;
    } event_t;

    typedef struct packed {
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic [19:0] rto;
        logic        fast_retransmit;
        logic        in_recovery;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

### sv/tcp_congestion_window_and_rto_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_congestion_window_and_rto_top: Reno congestion window and RTO control
// Per-connection sender control: one event in, one result out.
//
// Usage:
//   Events (new ACK, duplicate ACK, timeout) enter on in_valid/in_ready; each
//   transaction yields exactly one result transaction on out_valid/out_ready
//   carrying cwnd, ssthresh, rto and the recovery flags after the event.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   to be written only while the block is idle; the block does not enforce it.
// Sequencing:
//   One event is processed at a time. Without a growth step the event goes
//   from S_DECODE straight to S_FIN. The growth step max(1, mss*mss/cwnd)
//   runs the bit-serial multiplier in S_MUL, hands the product over to the
//   bit-serial divider and waits for it in S_DIV. An RTT sample on a new ACK
//   adds S_RTT1 and S_RTT2 before S_FIN. in_ready returns in the same cycle
//   as the result is loaded, so no new event is accepted before the result
//   of the last one has been loaded.
// Reset:
//   rst_n clears the state to cwnd 536, ssthresh 65535, rto 1000 and loads
//   the configuration defaults; no result is pending.
// Stall:
//   A finished result sits in the output register while the next event is
//   accepted and processed; the next result waits until out_ready frees it.
// ----------------------------------------------------------------------------
module tcp_congestion_window_and_rto_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire tcw_pkg::event_t                    in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output tcw_pkg::result_t                        out_data,
    input  wire logic                               cfg_write,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_RTT1   = 3'd4;
    localparam logic [2:0] S_RTT2   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]  state_reg, state_next;

    // Configuration
    logic [15:0] mss_reg;
    logic [3:0]  dup_thr_reg;
    logic [15:0] rto_floor_reg;
    logic [19:0] rto_ceil_reg;

    // Connection state
    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ss_reg, ss_next;
    logic [3:0]  dup_reg, dup_next;
    logic        rec_reg, rec_next;
    logic [19:0] srtt_reg, srtt_next;
    logic [19:0] rttvar_reg, rttvar_next;
    logic [19:0] rto_reg, rto_next;
    logic        fr_reg, fr_next;

    // Event and result holding
    tcw_pkg::event_t  item_reg, item_next;
    tcw_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    // Serial arithmetic units
    tcw_pkg::unit_stat_t mul_stat;
    tcw_pkg::unit_stat_t div_stat;
    logic        mul_start;
    logic        div_start;
    logic [31:0] mul_product;
    logic [31:0] div_quotient;
    logic [31:0] div_divisor;

    // Datapath terms
    logic [15:0] halve_w;
    logic [16:0] halve_t;
    logic [16:0] two_mss;
    logic [16:0] halve_ss;
    logic [17:0] three_mss;
    logic [32:0] fr_sum;
    logic [31:0] fr_cwnd;
    logic [3:0]  dup_inc;
    logic [31:0] cw_eff;
    logic [32:0] cw_dbl;
    logic [20:0] rto_dbl;
    logic [31:0] grow;
    logic [32:0] grow_sum;
    logic [15:0] rtt_r;
    logic [16:0] rtt_avg;
    logic [16:0] rtt_mag;
    logic [20:0] srtt_sum;
    logic [20:0] var_sum;
    logic [20:0] rto_sum;
    logic [19:0] rto_sat;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = res_valid_reg;
    assign out_data    = res_reg;
    assign div_divisor = (cwnd_reg == 32'd0) ? 32'd1 : cwnd_reg;
    assign div_start   = (state_reg == S_MUL) && mul_stat.done;

    tcw_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mss_reg),
        .mplier  (mss_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    tcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Shared combinational terms
    always_comb
    begin
        // ssthresh after a loss: max(min(cwnd, window) / 2, 2 * mss)
        halve_w   = (cwnd_reg < {16'd0, item_reg.peer_window}) ? cwnd_reg[15:0]
                                                               : item_reg.peer_window;
        halve_t   = {2'b00, halve_w[15:1]};
        two_mss   = {mss_reg, 1'b0};
        halve_ss  = (halve_t < two_mss) ? two_mss : halve_t;
        three_mss = {1'b0, mss_reg, 1'b0} + {2'b00, mss_reg};
        fr_sum    = {16'd0, halve_ss} + {15'd0, three_mss};
        fr_cwnd   = fr_sum[32] ? tcw_pkg::MAX32 : fr_sum[31:0];
        dup_inc   = (dup_reg == tcw_pkg::DUP_MAX) ? tcw_pkg::DUP_MAX : dup_reg + 4'd1;
        cw_eff    = rec_reg ? ss_reg : cwnd_reg;
        cw_dbl    = {cw_eff, 1'b0};
        rto_dbl   = {rto_reg, 1'b0};

        // growth step: max(1, quotient), saturating add
        grow      = (div_quotient == 32'd0) ? 32'd1 : div_quotient;
        grow_sum  = {1'b0, cwnd_reg} + {1'b0, grow};

        // RTT estimator, zero sample counts as one tick
        rtt_r     = (item_reg.rtt_ticks == 16'd0) ? 16'd1 : item_reg.rtt_ticks;
        rtt_avg   = srtt_reg[19:3];
        rtt_mag   = ({1'b0, rtt_r} >= rtt_avg) ? {1'b0, rtt_r} - rtt_avg
                                               : rtt_avg - {1'b0, rtt_r};
        srtt_sum  = {1'b0, srtt_reg - {3'd0, rtt_avg}} + {5'd0, rtt_r};
        var_sum   = {1'b0, rttvar_reg - {2'd0, rttvar_reg[19:2]}} + {4'd0, rtt_mag};
        rto_sum   = {4'd0, srtt_reg[19:3]} + {1'b0, rttvar_reg};
        rto_sat   = rto_sum[20] ? tcw_pkg::MAX20 : rto_sum[19:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cwnd_next      = cwnd_reg;
        ss_next        = ss_reg;
        dup_next       = dup_reg;
        rec_next       = rec_reg;
        srtt_next      = srtt_reg;
        rttvar_next    = rttvar_reg;
        rto_next       = rto_reg;
        fr_next        = fr_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        mul_start      = 1'b0;

        // drop the held result once it is taken
        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    fr_next    = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                case (item_reg.action)
                    tcw_pkg::ACT_NEW_ACK:
                    begin
                        dup_next = '0;
                        rec_next = 1'b0;
                        if (cw_eff < ss_reg)
                        begin
                            cwnd_next = (cw_dbl > {1'b0, ss_reg}) ? ss_reg : cw_dbl[31:0];
                            if (item_reg.rtt_valid)
                            begin
                                state_next = S_RTT1;
                            end
                        end
                        else
                        begin
                            cwnd_next  = cw_eff;
                            mul_start  = 1'b1;
                            state_next = S_MUL;
                        end
                    end
                    tcw_pkg::ACT_DUP_ACK:
                    begin
                        dup_next = dup_inc;
                        if (dup_inc >= dup_thr_reg)
                        begin
                            if (!rec_reg)
                            begin
                                ss_next   = {15'd0, halve_ss};
                                cwnd_next = fr_cwnd;
                                rec_next  = 1'b1;
                                fr_next   = 1'b1;
                            end
                            else
                            begin
                                mul_start  = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                    end
                    tcw_pkg::ACT_TIMEOUT:
                    begin
                        ss_next   = {15'd0, halve_ss};
                        cwnd_next = {16'd0, mss_reg};
                        rto_next  = (rto_dbl > {1'b0, rto_ceil_reg}) ? rto_ceil_reg
                                                                     : rto_dbl[19:0];
                    end
                    default:
                    begin
                        // unused code: report the state unchanged
                    end
                endcase
            end
            S_MUL:
            begin
                // the divider starts on the multiplier's done pulse
                if (mul_stat.done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    cwnd_next = grow_sum[32] ? tcw_pkg::MAX32 : grow_sum[31:0];
                    if ((item_reg.action == tcw_pkg::ACT_NEW_ACK) && item_reg.rtt_valid)
                    begin
                        state_next = S_RTT1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_RTT1:
            begin
                if (srtt_reg != 20'd0)
                begin
                    srtt_next   = srtt_sum[20] ? tcw_pkg::MAX20 : srtt_sum[19:0];
                    rttvar_next = var_sum[20] ? tcw_pkg::MAX20 : var_sum[19:0];
                end
                else
                begin
                    srtt_next   = {1'b0, rtt_r, 3'b000};
                    rttvar_next = {3'b000, rtt_r, 1'b0};
                end
                state_next = S_RTT2;
            end
            S_RTT2:
            begin
                rto_next   = (rto_sat < {4'd0, rto_floor_reg}) ? {4'd0, rto_floor_reg}
                                                               : rto_sat;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold here until the output register is free
                if (!res_valid_reg || out_ready)
                begin
                    res_next.cwnd            = cwnd_reg;
                    res_next.ssthresh        = ss_reg;
                    res_next.rto             = rto_reg;
                    res_next.fast_retransmit = fr_reg;
                    res_next.in_recovery     = rec_reg;
                    res_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and connection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            cwnd_reg      <= tcw_pkg::RST_CWND;
            ss_reg        <= tcw_pkg::RST_SSTHRESH;
            dup_reg       <= '0;
            rec_reg       <= 1'b0;
            srtt_reg      <= '0;
            rttvar_reg    <= '0;
            rto_reg       <= tcw_pkg::RST_RTO;
            fr_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cwnd_reg      <= cwnd_next;
            ss_reg        <= ss_next;
            dup_reg       <= dup_next;
            rec_reg       <= rec_next;
            srtt_reg      <= srtt_next;
            rttvar_reg    <= rttvar_next;
            rto_reg       <= rto_next;
            fr_reg        <= fr_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg       <= tcw_pkg::RST_SEGMENT_SIZE;
            dup_thr_reg   <= tcw_pkg::RST_DUP_THRESHOLD;
            rto_floor_reg <= tcw_pkg::RST_RTO_FLOOR;
            rto_ceil_reg  <= tcw_pkg::RST_RTO_CEILING;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tcw_pkg::REG_SEGMENT_SIZE:  mss_reg       <= cfg_data[15:0];
                tcw_pkg::REG_DUP_THRESHOLD: dup_thr_reg   <= cfg_data[3:0];
                tcw_pkg::REG_RTO_FLOOR:     rto_floor_reg <= cfg_data[15:0];
                tcw_pkg::REG_RTO_CEILING:   rto_ceil_reg  <= cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // Assertions
    a_fr_in_recovery: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.fast_retransmit || out_data.in_recovery))
        else $error("fast retransmit reported outside recovery");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction did not start decode");

endmodule

`default_nettype wire

### sv/tcw_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_mul: bit-serial 16 x 16 multiplier
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcw_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [15:0]       mcand,
    input  wire logic [15:0]       mplier,
    output tcw_pkg::unit_stat_t    stat,
    output logic      [31:0]       product
);

    logic [15:0] acc_reg, acc_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] m_reg, m_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] sum;

    always_comb
    begin
        sum       = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, m_reg} : 17'd0);
        acc_next  = acc_reg;
        q_next    = q_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            q_next    = mplier;
            m_next    = mcand;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add and shift the {acc, q} pair right by one
            acc_next = sum[16:1];
            q_next   = {sum[0], q_reg[15:1]};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
    end

    assign product   = {acc_reg, q_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### sv/tcw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_div: bit-serial 32 / 32 unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcw_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [31:0]       dividend,
    input  wire logic [31:0]       divisor,
    output tcw_pkg::unit_stat_t    stat,
    output logic      [31:0]       quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### tb/tcp_congestion_window_and_rto_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_congestion_window_and_rto_top_test: self-checking bench for Reno cwnd/RTO
// Drives ACK, duplicate ACK and timeout events through the valid/ready input
// and checks every result against a cycle-free model of the window,
// threshold, recovery and RTT estimator state kept here. The sender runs in
// bursts and the receiver stalls on its own pattern. Directed cases cover the
// reset defaults, a zero segment size and a very large growth step. Random
// phases then run recovery cycles, ACK runs and timeout backoff under
// several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tcp_congestion_window_and_rto_top_test;

    // Action code 3 is not assigned; the block must report state unchanged
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int MAX_MISMATCH_LINES = 40;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    tcw_pkg::event_t                in_data;
    logic                           out_valid;
    logic                           out_ready;
    tcw_pkg::result_t               out_data;
    logic                           cfg_write;
    logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data;

    // Local copy of the configuration registers
    logic [15:0] cfg_mss;
    logic [3:0]  cfg_dup_thresh;
    logic [15:0] cfg_rto_min;
    logic [19:0] cfg_rto_max;

    // Local copy of the per-connection state
    logic [31:0] win_cwnd;
    logic [31:0] win_ssthresh;
    logic [3:0]  dup_seen;
    logic        in_fast_recovery;
    logic [19:0] srtt_scaled;
    logic [19:0] rttvar_scaled;
    logic [19:0] rto_ticks;

    // Results still owed by the block, oldest first
    tcw_pkg::result_t expected_results[$];

    int error_count        = 0;
    int items_sent         = 0;
    int results_seen       = 0;
    int recoveries_entered = 0;
    int timeouts_sent      = 0;
    int config_phases      = 0;
    int burst_left         = 0;
    int hold_cycles        = 0;
    int holds_done         = 0;

    tcp_congestion_window_and_rto_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Window arithmetic
    // ------------------------------------------------------------------
    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? tcw_pkg::MAX32 : v[31:0];
    endfunction

    function automatic logic [19:0] clamp20(input logic [63:0] v);
        return (v > 64'hF_FFFF) ? tcw_pkg::MAX20 : v[19:0];
    endfunction

    // Congestion avoidance increment max(1, mss*mss/cwnd); a zero cwnd
    // divides by one
    function automatic logic [63:0] growth_increment();
        logic [63:0] m;
        logic [63:0] d;
        logic [63:0] q;
        m = {48'd0, cfg_mss};
        d = (win_cwnd == 32'd0) ? 64'd1 : {32'd0, win_cwnd};
        q = (m * m) / d;
        return (q == 64'd0) ? 64'd1 : q;
    endfunction

    // Half of min(cwnd, peer window), never below two segments
    function automatic logic [31:0] lowered_threshold(input logic [15:0] peer_win);
        logic [63:0] w;
        logic [63:0] lo;
        w = (win_cwnd < {16'd0, peer_win}) ? {32'd0, win_cwnd} : {48'd0, peer_win};
        w = w >> 1;
        lo = {48'd0, cfg_mss};
        lo = lo * 64'd2;
        return (w < lo) ? lo[31:0] : w[31:0];
    endfunction

    // Advance the local state by one accepted event and return the result
    // the block must produce for it
    function automatic tcw_pkg::result_t apply_event(input tcw_pkg::event_t item);
        tcw_pkg::result_t r;
        logic [63:0]      wide;
        logic [63:0]      smp;
        logic [63:0]      avg;
        logic [63:0]      mag;
        logic             fr;
        fr = 1'b0;
        case (item.action)
            tcw_pkg::ACT_DUP_ACK:
            begin
                if (dup_seen != tcw_pkg::DUP_MAX)
                    dup_seen = dup_seen + 4'd1;
                if (dup_seen >= cfg_dup_thresh)
                begin
                    if (!in_fast_recovery)
                    begin
                        win_ssthresh = lowered_threshold(item.peer_window);
                        wide = {48'd0, cfg_mss};
                        wide = wide * 64'd3 + {32'd0, win_ssthresh};
                        win_cwnd = clamp32(wide);
                        in_fast_recovery = 1'b1;
                        fr = 1'b1;
                    end
                    else
                    begin
                        wide = {32'd0, win_cwnd};
                        win_cwnd = clamp32(wide + growth_increment());
                    end
                end
            end
            tcw_pkg::ACT_NEW_ACK:
            begin
                dup_seen = 4'd0;
                if (in_fast_recovery)
                begin
                    in_fast_recovery = 1'b0;
                    win_cwnd = win_ssthresh;
                end
                if (win_cwnd < win_ssthresh)
                begin
                    // slow start, capped at the threshold
                    wide = {32'd0, win_cwnd};
                    wide = wide * 64'd2;
                    win_cwnd = (wide > {32'd0, win_ssthresh}) ? win_ssthresh : wide[31:0];
                end
                else
                begin
                    wide = {32'd0, win_cwnd};
                    win_cwnd = clamp32(wide + growth_increment());
                end
                if (item.rtt_valid)
                begin
                    smp = (item.rtt_ticks == 16'd0) ? 64'd1 : {48'd0, item.rtt_ticks};
                    if (srtt_scaled != 20'd0)
                    begin
                        avg = {47'd0, srtt_scaled[19:3]};
                        mag = (smp >= avg) ? smp - avg : avg - smp;
                        wide = {44'd0, srtt_scaled};
                        srtt_scaled = clamp20(wide - avg + smp);
                        wide = {44'd0, rttvar_scaled};
                        rttvar_scaled = clamp20(wide - (wide >> 2) + mag);
                    end
                    else
                    begin
                        // first sample seeds both estimators
                        srtt_scaled = clamp20(smp << 3);
                        rttvar_scaled = clamp20(smp << 1);
                    end
                    wide = {47'd0, srtt_scaled[19:3]};
                    wide = wide + {44'd0, rttvar_scaled};
                    rto_ticks = clamp20(wide);
                    if (rto_ticks < {4'd0, cfg_rto_min})
                        rto_ticks = {4'd0, cfg_rto_min};
                end
            end
            tcw_pkg::ACT_TIMEOUT:
            begin
                win_ssthresh = lowered_threshold(item.peer_window);
                win_cwnd = {16'd0, cfg_mss};
                wide = {44'd0, rto_ticks};
                wide = wide * 64'd2;
                rto_ticks = (wide > {44'd0, cfg_rto_max}) ? cfg_rto_max : wide[19:0];
            end
            default:
            begin
            end
        endcase
        if (fr)
            recoveries_entered++;
        r.cwnd            = win_cwnd;
        r.ssthresh        = win_ssthresh;
        r.rto             = rto_ticks;
        r.fast_retransmit = fr;
        r.in_recovery     = in_fast_recovery;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic tcw_pkg::event_t event_of(input logic [1:0] act,
                                                 input logic [15:0] peer_win,
                                                 input logic with_rtt,
                                                 input logic [15:0] ticks);
        tcw_pkg::event_t e;
        e.action      = act;
        e.peer_window = peer_win;
        e.rtt_valid   = with_rtt;
        e.rtt_ticks   = ticks;
        return e;
    endfunction

    // Random content for one event: windows lean toward the small end and
    // the extremes, RTT samples toward realistic values with some zeros and
    // saturated ones
    function automatic tcw_pkg::event_t random_event(input logic [1:0] act);
        tcw_pkg::event_t e;
        int              pick;
        e.action = act;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            e.peer_window = 16'd0;
        else if (pick == 1)
            e.peer_window = 16'hFFFF;
        else if (pick < 5)
            e.peer_window = 16'($urandom_range(0, 4000));
        else
            e.peer_window = 16'($urandom);
        if (act == tcw_pkg::ACT_NEW_ACK)
            e.rtt_valid = ($urandom_range(0, 3) != 0);
        else
            e.rtt_valid = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            e.rtt_ticks = 16'd0;
        else if (pick == 1)
            e.rtt_ticks = 16'hFFFF;
        else if (pick < 6)
            e.rtt_ticks = 16'($urandom_range(1, 600));
        else
            e.rtt_ticks = 16'($urandom);
        return e;
    endfunction

    // Offer one event and hold it until accepted. Called at a falling edge;
    // returns at the falling edge after acceptance with valid still high so
    // that a following event goes out without a bubble. Bursts of random
    // length are separated by random gaps.
    task automatic send_event(input tcw_pkg::event_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_data  = item;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(apply_event(item));
        items_sent++;
        if (item.action == tcw_pkg::ACT_TIMEOUT)
            timeouts_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has been taken, then
    // let the block settle
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write all four registers while the block is idle; state is kept
    task automatic apply_config(input logic [15:0] mss, input logic [3:0] thresh,
                                input logic [15:0] rto_min, input logic [19:0] rto_max);
        logic [tcw_pkg::CFG_DATA_W-1:0] vals[4];
        logic [tcw_pkg::CFG_IDX_W-1:0]  idx[4];
        idx  = '{tcw_pkg::REG_SEGMENT_SIZE, tcw_pkg::REG_DUP_THRESHOLD,
                 tcw_pkg::REG_RTO_FLOOR, tcw_pkg::REG_RTO_CEILING};
        vals = '{{4'd0, mss}, {16'd0, thresh}, {4'd0, rto_min}, rto_max};
        wait_for_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_index = idx[i];
            cfg_data  = vals[i];
            cfg_write = 1'b1;
            @(negedge clk);
        end
        cfg_write      = 1'b0;
        cfg_mss        = mss;
        cfg_dup_thresh = thresh;
        cfg_rto_min    = rto_min;
        cfg_rto_max    = rto_max;
        config_phases++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: slow start, first RTT sample of zero, RTO floor,
    // fast recovery entry and inflation, the unused action, an RTT sample
    // on a non-ACK, timeouts with both window extremes, and a duplicate ACK
    // that stays below the threshold
    task automatic test_reset_defaults();
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'h0000, 1'b1, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'hFFFF, 1'b1, 16'hFFFF));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'hFFFF, 1'b1, 16'h0005));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'hFFFF, 1'b0, 16'hFFFF));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'h0000, 1'b0, 16'h0000));
        send_event(event_of(ACT_UNUSED,           16'hFFFF, 1'b1, 16'hFFFF));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'h0000, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_TIMEOUT, 16'h0000, 1'b1, 16'h0007));
        send_event(event_of(tcw_pkg::ACT_TIMEOUT, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'h1234, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'h1234, 1'b1, 16'h0003));
    endtask

    // Segment size zero drives cwnd to zero, where the growth divisor
    // falls back to one
    task automatic test_zero_segment();
        apply_config(16'd0, 4'd1, tcw_pkg::RST_RTO_FLOOR, tcw_pkg::RST_RTO_CEILING);
        send_event(event_of(tcw_pkg::ACT_TIMEOUT, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_TIMEOUT, 16'h0000, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'h0000, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'h0000, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'h0000, 1'b1, 16'h0100));
    endtask

    // Collapse cwnd with a one-byte segment, then raise the segment size to
    // its maximum so the growth step is close to 2^31
    task automatic test_big_growth_step();
        apply_config(16'd1, tcw_pkg::RST_DUP_THRESHOLD, tcw_pkg::RST_RTO_FLOOR,
                     tcw_pkg::RST_RTO_CEILING);
        send_event(event_of(tcw_pkg::ACT_TIMEOUT, 16'h0000, 1'b0, 16'h0000));
        apply_config(16'hFFFF, tcw_pkg::RST_DUP_THRESHOLD, tcw_pkg::RST_RTO_FLOOR,
                     tcw_pkg::RST_RTO_CEILING);
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'hFFFF, 1'b1, 16'h0040));
        for (int i = 0; i < 4; i++)
            send_event(event_of(tcw_pkg::ACT_DUP_ACK, 16'hFFFF, 1'b0, 16'h0000));
        send_event(event_of(tcw_pkg::ACT_NEW_ACK, 16'h8000, 1'b0, 16'h0000));
    endtask

    // Hold the result side off for a long stretch while events keep coming,
    // so the output register fills and the input stalls; then pause the
    // sender until everything owed has been delivered
    task automatic test_output_backpressure();
        apply_config(tcw_pkg::RST_SEGMENT_SIZE, tcw_pkg::RST_DUP_THRESHOLD,
                     tcw_pkg::RST_RTO_FLOOR, tcw_pkg::RST_RTO_CEILING);
        hold_cycles = 400;
        for (int i = 0; i < 16; i++)
            send_event(random_event(2'($urandom_range(0, 2))));
        wait_for_results();
    endtask

    // One configuration phase of random traffic, mostly well-formed
    // sequences: ACK runs, duplicate bursts around the threshold that end in
    // a new ACK, timeout backoff chains, and some raw noise
    task automatic run_random_phase(input logic [15:0] mss, input logic [3:0] thresh,
                                    input logic [15:0] rto_min, input logic [19:0] rto_max,
                                    input int quota);
        int stop_at;
        int pick;
        int n;
        int lo;
        apply_config(mss, thresh, rto_min, rto_max);
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                n = $urandom_range(2, 12);
                repeat (n) send_event(random_event(tcw_pkg::ACT_NEW_ACK));
            end
            else if (pick < 75)
            begin
                lo = (thresh > 4'd1) ? int'(thresh) - 1 : 1;
                n = $urandom_range(lo, int'(thresh) + 6);
                repeat (n) send_event(random_event(tcw_pkg::ACT_DUP_ACK));
                send_event(random_event(tcw_pkg::ACT_NEW_ACK));
            end
            else if (pick < 87)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
                repeat (n) send_event(random_event(tcw_pkg::ACT_TIMEOUT));
            end
            else
            begin
                send_event(random_event(2'($urandom_range(0, 3))));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(tcw_pkg::RST_SEGMENT_SIZE, tcw_pkg::RST_DUP_THRESHOLD,
                         tcw_pkg::RST_RTO_FLOOR, tcw_pkg::RST_RTO_CEILING, 150);
        run_random_phase(16'd1, 4'd1, 16'd1, 20'd1, 140);
        run_random_phase(16'hFFFF, 4'd15, 16'hFFFF, 20'hFFFFF, 150);
        run_random_phase(16'd1460, 4'd2, 16'd1000, 20'd120000, 140);
        for (int i = 0; i < 4; i++)
            run_random_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)),
                             16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                             150);
    endtask

    // ------------------------------------------------------------------
    // Receiver: out_ready changes at the falling edge. It switches between
    // always ready, coin flip, mostly stalled and a fixed duty pattern, and
    // serves a long hold-off when the test posts one.
    // ------------------------------------------------------------------
    initial
    begin : ready_pattern
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                out_ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       out_ready = 1'b1;
                1:       out_ready = 1'($urandom_range(0, 1));
                2:       out_ready = ($urandom_range(0, 3) == 0);
                default: out_ready = ((tick % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each delivered result with the oldest owed one
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            if (error_count < MAX_MISMATCH_LINES)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tcw_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                if (error_count < MAX_MISMATCH_LINES)
                    $display("%0t: unexpected result, expected none, got cwnd %0d ssthresh %0d",
                             $time, out_data.cwnd, out_data.ssthresh);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("cwnd", want.cwnd, out_data.cwnd);
                check_field("ssthresh", want.ssthresh, out_data.ssthresh);
                check_field("rto", {12'd0, want.rto}, {12'd0, out_data.rto});
                check_field("fast_retransmit", {31'd0, want.fast_retransmit},
                            {31'd0, out_data.fast_retransmit});
                check_field("in_recovery", {31'd0, want.in_recovery},
                            {31'd0, out_data.in_recovery});
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        cfg_mss          = tcw_pkg::RST_SEGMENT_SIZE;
        cfg_dup_thresh   = tcw_pkg::RST_DUP_THRESHOLD;
        cfg_rto_min      = tcw_pkg::RST_RTO_FLOOR;
        cfg_rto_max      = tcw_pkg::RST_RTO_CEILING;
        win_cwnd         = tcw_pkg::RST_CWND;
        win_ssthresh     = tcw_pkg::RST_SSTHRESH;
        dup_seen         = 4'd0;
        in_fast_recovery = 1'b0;
        srtt_scaled      = 20'd0;
        rttvar_scaled    = 20'd0;
        rto_ticks        = tcw_pkg::RST_RTO;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_zero_segment();
        test_big_growth_step();
        test_output_backpressure();
        test_random_traffic();

        // Drain, then give any stray result time to show up
        wait_for_results();
        repeat (100) @(negedge clk);

        $display("run covered %0d events over %0d register settings,", items_sent,
                 config_phases);
        $display("%0d recovery entries, %0d timeouts, %0d results checked, %0d long holds",
                 recoveries_entered, timeouts_sent, results_seen, holds_done);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: several times what the slowest correct run needs
    initial
    begin : watchdog
        #8_000_000;
        $display("%0t: timeout with %0d results still owed", $time, expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
